// ===== design/line_resampler_interp_macros.svh =====
// assertion macros for the line resampler checker
`ifndef LINE_RESAMPLER_INTERP_MACROS_SVH
`define LINE_RESAMPLER_INTERP_MACROS_SVH

// checked only outside reset
`define LRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LRI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/lri_pkg.sv =====
// shared types and constants of the line resampler
package lri_pkg;

  localparam int unsigned STEP_W   = 24;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LIDX_W   = 10;
  localparam int unsigned POS_W    = 40;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned NTAPS    = 4;

  localparam int unsigned LINE_DEPTH_DEF     = 1024;
  localparam int unsigned OUT_INDEX_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ALPHA  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_LENGTH = 2'd3;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic [DIST_W-1:0] ONE_Q16 = 18'h10000;
  localparam logic [DIST_W-1:0] TWO_Q16 = 18'h20000;

  typedef enum logic [1:0] {
    MODE_NEAREST,
    MODE_BILINEAR,
    MODE_CUBIC,
    MODE_BSPLINE
  } mode_e;

  typedef struct packed {
    mode_e                      mode;
    logic [STEP_W-1:0]          step;
    logic signed [ALPHA_W-1:0]  alpha;
    logic [LEN_W-1:0]           source_length;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [LIDX_W-1:0]  load_index;
    logic [PIX_W-1:0]   pixel;
    logic [POS_W-1:0]   pos;
  } item_t;

endpackage

// ===== design/line_resampler_interp.sv =====
// top level of the one-dimensional line resampler
//
// Input channel: in_valid_i / in_stall_o with kind_i, load_index_i, pixel_in_i and
// out_index_i. A load request writes one pixel into the line store and gives no
// result; a compute request gives exactly one pixel_out_o on the output channel
// out_valid_o / out_stall_i, in request order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (mode, step,
// alpha, source length); write only while no request is in flight.
// Throughput: one request per clock while in_stall_o is low. Each result passes the
// position multiply, queue, tap read, two power stages, weight poly, alpha multiply,
// tap multiply, sum and round registers. The line store is held four times, one copy
// per tap, so all four taps come from separate read ports in the same cycle.
// Reset: pipeline and queue empty, registers at mode bilinear, step 1.0,
// alpha -0.5, length 1024; the line store is not cleared.
// A stalled output holds its pixel and freezes the back end; the four entry queue
// then fills and in_stall_o rises.
module line_resampler_interp #(
  parameter int unsigned LINE_DEPTH     = lri_pkg::LINE_DEPTH_DEF,
  parameter int unsigned OUT_INDEX_BITS = lri_pkg::OUT_INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lri_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [lri_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [lri_pkg::LIDX_W-1:0]  load_index_i,
  input  logic [lri_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic [OUT_INDEX_BITS-1:0]   out_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lri_pkg::PIX_W-1:0]   pixel_out_o
);
  import lri_pkg::*;

  cfg_t  cfg_q;
  item_t f_item, q_item;
  logic  f_valid, q_ready, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_BILINEAR;
      cfg_q.step          <= STEP_W'(65536);
      cfg_q.alpha         <= -16'sd8192;
      cfg_q.source_length <= LEN_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:   cfg_q.mode          <= mode_e'(cfg_data_i[1:0]);
        REG_STEP:   cfg_q.step          <= cfg_data_i[STEP_W-1:0];
        REG_ALPHA:  cfg_q.alpha         <= $signed(cfg_data_i[ALPHA_W-1:0]);
        REG_LENGTH: cfg_q.source_length <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lri_front #(
    .OUT_INDEX_BITS(OUT_INDEX_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .load_index_i (load_index_i),
    .pixel_in_i   (pixel_in_i),
    .out_index_i  (out_index_i),
    .step_i       (cfg_q.step),
    .item_valid_o (f_valid),
    .item_ready_i (q_ready),
    .item_o       (f_item)
  );

  lri_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  lri_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o)
  );

endmodule

// ===== design/lri_front.sv =====
// front end: request intake and source position multiply
module lri_front #(
  parameter int unsigned OUT_INDEX_BITS = lri_pkg::OUT_INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [lri_pkg::LIDX_W-1:0]  load_index_i,
  input  logic [lri_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic [OUT_INDEX_BITS-1:0]   out_index_i,
  input  logic [lri_pkg::STEP_W-1:0]  step_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output lri_pkg::item_t              item_o
);
  import lri_pkg::*;

  localparam int unsigned PW = OUT_INDEX_BITS + STEP_W;

  logic          valid_q;
  item_t         item_q, item_d;
  logic [PW-1:0] prod;

  assign prod = PW'(out_index_i) * PW'(step_i);

  always_comb begin
    item_d.kind       = kind_i;
    item_d.load_index = load_index_i;
    item_d.pixel      = pixel_in_i;
    item_d.pos        = POS_W'(prod);
  end

  assign in_stall_o   = valid_q & ~item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/lri_queue.sv =====
// short request queue between front and back end
module lri_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lri_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output lri_pkg::item_t item_o
);
  import lri_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign ready_o = count_q != CW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/lri_back.sv =====
// back end: line store, tap reads, kernel weights and accumulation
module lri_back #(
  parameter int unsigned LINE_DEPTH = lri_pkg::LINE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  input  lri_pkg::item_t             item_i,
  output logic                       pop_o,
  input  lri_pkg::cfg_t              cfg_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lri_pkg::PIX_W-1:0]  pixel_out_o
);
  import lri_pkg::*;

  localparam int unsigned AW     = $clog2(LINE_DEPTH);
  localparam int unsigned LW     = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IW     = POS_W - FRAC_W + 3;
  localparam int unsigned SQ_W   = 19;
  localparam int unsigned CU_W   = 20;
  localparam int unsigned POLY_W = 26;
  localparam int unsigned W_W    = 48;
  localparam int unsigned AP_W   = ALPHA_W + POLY_W;
  localparam int unsigned PROD_W = W_W + PIX_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic en, pop, wr;
  logic [AW-1:0] waddr;

  // head of queue decode
  logic [LW-1:0]           len_c, last_c;
  logic [POS_W-FRAC_W-1:0] fl;
  logic [FRAC_W-1:0]       frac;
  logic [POS_W:0]          rnd_sum;
  logic signed [IW-1:0]    base;
  logic signed [IW-1:0]    idx  [NTAPS];
  logic [AW-1:0]           addr [NTAPS];
  logic [DIST_W-1:0]       dist0 [NTAPS];
  logic [PIX_W-1:0]        tap1 [NTAPS];

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_valid_q;
  mode_e mode1_q, mode2_q, mode3_q, mode4_q, mode5_q, mode6_q, mode7_q;
  logic [DIST_W-1:0]        dist1_q [NTAPS];
  logic [DIST_W-1:0]        dist2_q [NTAPS];
  logic [DIST_W-1:0]        dist3_q [NTAPS];
  logic [SQ_W-1:0]          sq2_q [NTAPS];
  logic [SQ_W-1:0]          sq3_q [NTAPS];
  logic [CU_W-1:0]          cu3_q [NTAPS];
  logic [PIX_W-1:0]         tap2_q [NTAPS];
  logic [PIX_W-1:0]         tap3_q [NTAPS];
  logic [PIX_W-1:0]         tap4_q [NTAPS];
  logic [PIX_W-1:0]         tap5_q [NTAPS];
  logic signed [POLY_W-1:0] poly4_q [NTAPS];
  logic signed [W_W-1:0]    oth4_q [NTAPS];
  logic signed [W_W-1:0]    w5_q [NTAPS];
  logic signed [PROD_W-1:0] prod6_q [NTAPS];
  logic signed [SUM_W-1:0]  sum7_q;
  logic [PIX_W-1:0]         pixel_q;

  logic [SQ_W-1:0]          sq_d [NTAPS];
  logic [CU_W-1:0]          cu_d [NTAPS];
  logic signed [POLY_W-1:0] poly_d [NTAPS];
  logic signed [W_W-1:0]    oth_d [NTAPS];
  logic signed [W_W-1:0]    w_d [NTAPS];
  logic signed [PROD_W-1:0] prod_d [NTAPS];
  logic signed [SUM_W-1:0]  sum_d;
  logic [PIX_W-1:0]         pixel_d;

  assign en          = ~out_valid_q | ~out_stall_i;
  assign pop         = item_valid_i & en;
  assign pop_o       = pop;
  assign wr          = pop && (item_i.kind == KIND_LOAD) && (32'(item_i.load_index) < LINE_DEPTH);
  assign waddr       = AW'(item_i.load_index);
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

  // effective line length and tap addresses
  always_comb begin
    if (cfg_i.source_length == '0) begin
      len_c = LW'(1);
    end else if (32'(cfg_i.source_length) > LINE_DEPTH) begin
      len_c = LW'(LINE_DEPTH);
    end else begin
      len_c = LW'(cfg_i.source_length);
    end
    last_c  = len_c - LW'(1);
    fl      = item_i.pos[POS_W-1:FRAC_W];
    frac    = item_i.pos[FRAC_W-1:0];
    rnd_sum = {1'b0, item_i.pos} + (POS_W+1)'(32'h8000);
    if (cfg_i.mode == MODE_NEAREST) begin
      base = $signed(IW'(rnd_sum[POS_W:FRAC_W])) - IW'(1);
    end else begin
      base = $signed(IW'(fl)) - IW'(1);
    end
    for (int k = 0; k < NTAPS; k++) begin
      idx[k] = base + IW'(k);
      if (idx[k][IW-1]) begin
        addr[k] = '0;
      end else if (idx[k] > $signed(IW'(last_c))) begin
        addr[k] = AW'(last_c);
      end else begin
        addr[k] = AW'(idx[k]);
      end
    end
    dist0[0] = ONE_Q16 + DIST_W'(frac);
    dist0[1] = DIST_W'(frac);
    dist0[2] = ONE_Q16 - DIST_W'(frac);
    dist0[3] = TWO_Q16 - DIST_W'(frac);
  end

  // one copy of the line per tap so all four read in the same cycle
  for (genvar g = 0; g < NTAPS; g++) begin : g_bank
    logic [PIX_W-1:0] mem [LINE_DEPTH];
    logic [PIX_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (wr) mem[waddr] <= item_i.pixel;
      if (en) rd_q <= mem[addr[g]];
    end
    assign tap1[g] = rd_q;
  end

  // kernel arithmetic per tap
  always_comb begin
    logic [2*DIST_W-1:0]   p2;
    logic [SQ_W+DIST_W-1:0] p3;
    logic signed [W_W-1:0] dd, d2s, d3s, tmp;
    logic                  near;
    logic signed [AP_W-1:0] ap;
    logic signed [PIX_W:0]  tp;
    sum_d = '0;
    for (int k = 0; k < NTAPS; k++) begin
      p2       = (2*DIST_W)'(dist1_q[k]) * (2*DIST_W)'(dist1_q[k]);
      sq_d[k]  = p2[FRAC_W+SQ_W-1:FRAC_W];
      p3       = (SQ_W+DIST_W)'(sq2_q[k]) * (SQ_W+DIST_W)'(dist2_q[k]);
      cu_d[k]  = p3[FRAC_W+CU_W-1:FRAC_W];

      dd   = $signed(W_W'(dist3_q[k]));
      d2s  = $signed(W_W'(sq3_q[k]));
      d3s  = $signed(W_W'(cu3_q[k]));
      near = dist3_q[k] <= ONE_Q16;
      tmp  = '0;
      oth_d[k] = '0;
      case (mode3_q)
        MODE_CUBIC: begin
          if (near) begin
            tmp      = d3s - d2s;
            oth_d[k] = (d3s <<< 15) - 48'sd3 * (d2s <<< 14) + 48'sd1073741824;
          end else begin
            tmp = d3s - 48'sd5 * d2s + 48'sd8 * dd - 48'sd262144;
          end
        end
        MODE_BSPLINE: begin
          if (near) begin
            oth_d[k] = 48'sd3 * d3s - 48'sd6 * d2s + 48'sd262144;
          end else begin
            oth_d[k] = 48'sd6 * d2s - d3s - 48'sd12 * dd + 48'sd524288;
          end
        end
        MODE_BILINEAR: begin
          if (k == 1 || k == 2) oth_d[k] = 48'sd65536 - dd;
        end
        default: begin
          if (k == 1) oth_d[k] = 48'sd65536;
        end
      endcase
      poly_d[k] = POLY_W'(tmp);

      ap        = cfg_i.alpha * poly4_q[k];
      w_d[k]    = W_W'(ap) + oth4_q[k];

      // a tap with zero weight adds nothing, whatever its entry holds
      tp        = $signed({1'b0, tap5_q[k]});
      if (w5_q[k] == '0) begin
        prod_d[k] = '0;
      end else begin
        prod_d[k] = w5_q[k] * tp;
      end

      sum_d     = sum_d + SUM_W'(prod6_q[k]);
    end
  end

  // rounding and saturation
  always_comb begin
    logic signed [SUM_W-1:0] x;
    logic [SUM_W-1:0]        y;
    logic [20:0]             t;
    t = '0;
    case (mode7_q)
      MODE_CUBIC: begin
        x = sum7_q + SUM_W'(64'sd536870912);
        y = SUM_W'(x >>> 30);
      end
      MODE_BSPLINE: begin
        x = sum7_q + SUM_W'(64'sd196608);
        y = SUM_W'(x >>> 17);
      end
      default: begin
        x = sum7_q + SUM_W'(64'sd32768);
        y = SUM_W'(x >>> 16);
      end
    endcase
    if (x[SUM_W-1]) begin
      pixel_d = '0;
    end else if (mode7_q == MODE_BSPLINE) begin
      if (y >= SUM_W'(768)) begin
        pixel_d = 8'd255;
      end else begin
        t       = 21'(y[9:0]) * 21'd683;
        pixel_d = t[18:11];
      end
    end else if (y > SUM_W'(255)) begin
      pixel_d = 8'd255;
    end else begin
      pixel_d = y[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop && (item_i.kind == KIND_COMPUTE);
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= cfg_i.mode;
      mode2_q <= mode1_q;
      mode3_q <= mode2_q;
      mode4_q <= mode3_q;
      mode5_q <= mode4_q;
      mode6_q <= mode5_q;
      mode7_q <= mode6_q;
      for (int k = 0; k < NTAPS; k++) begin
        dist1_q[k] <= dist0[k];
        dist2_q[k] <= dist1_q[k];
        dist3_q[k] <= dist2_q[k];
        sq2_q[k]   <= sq_d[k];
        sq3_q[k]   <= sq2_q[k];
        cu3_q[k]   <= cu_d[k];
        tap2_q[k]  <= tap1[k];
        tap3_q[k]  <= tap2_q[k];
        tap4_q[k]  <= tap3_q[k];
        tap5_q[k]  <= tap4_q[k];
        poly4_q[k] <= poly_d[k];
        oth4_q[k]  <= oth_d[k];
        w5_q[k]    <= w_d[k];
        prod6_q[k] <= prod_d[k];
      end
      sum7_q  <= sum_d;
      pixel_q <= pixel_d;
    end
  end

endmodule

// ===== design/lri_checker.sv =====
// port level checks of the line resampler and their binding
`include "line_resampler_interp_macros.svh"

module lri_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lri_pkg::PIX_W-1:0]  pixel_out_o
);

  `LRI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o), "stalled result changed")
  `LRI_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result shown in reset")
  `LRI_ASSERT_RST(a_no_stall_in_reset, !rst_ni |-> !in_stall_o, "intake stalled in reset")
  `LRI_ASSERT_RST(a_no_result_after_reset, $rose(rst_ni) |-> !out_valid_o, "result right after reset")

endmodule

bind line_resampler_interp lri_checker u_lri_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the line resampler with its own pixel predictor
`timescale 1ns / 100ps

module testbench;
  import lri_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int WATCHDOG    = 4000;
  localparam int LONG_HOLD   = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              kind_i = KIND_LOAD;
  logic [LIDX_W-1:0] load_index_i = '0;
  logic [PIX_W-1:0]  pixel_in_i = '0;
  logic [11:0]       out_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PIX_W-1:0]  pixel_out_o;

  line_resampler_interp DUT (.*);

  always #1 clk_i = ~clk_i;

  // predictor copy of the block state
  mode_e        cur_mode;
  int unsigned  cur_step;
  int           cur_alpha;
  int unsigned  cur_len;
  logic [7:0]   line_px [STORE_DEPTH];
  bit           line_set [STORE_DEPTH];

  logic [7:0]   pixel_q [$];
  int           errors;
  bit           tx_idle, rx_idle, burst, hold_req;
  int           hold;
  int           quiet;

  typedef struct {
    logic       kind;
    int         lidx;
    int         pix;
    int         oi;
    bit         typed;
    int         want;
  } row_t;

  row_t directed [] = '{
    '{KIND_LOAD, 0, 0, 0, 0, 0},
    '{KIND_LOAD, 1, 255, 0, 0, 0},
    '{KIND_LOAD, 2, 128, 4095, 0, 0},
    '{KIND_LOAD, 1023, 255, 0, 0, 0},
    '{KIND_LOAD, 1022, 0, 0, 0, 0},
    '{KIND_COMPUTE, 1023, 255, 0, 1, 0},
    '{KIND_COMPUTE, 0, 0, 1, 1, 255},
    '{KIND_COMPUTE, 0, 0, 1022, 1, 0},
    '{KIND_COMPUTE, 0, 0, 1023, 1, 255},
    '{KIND_COMPUTE, 0, 0, 4095, 1, 255},
    '{KIND_COMPUTE, 0, 0, 2, 0, 0},
    '{KIND_LOAD, 1, 0, 0, 0, 0},
    '{KIND_COMPUTE, 0, 0, 0, 0, 0},
    '{KIND_COMPUTE, 0, 0, 1, 0, 0}
  };

  task automatic report(string what, int got, int want);
    $display("error: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int clamp_tap(longint idx);
    longint last;
    last = longint'(cur_len) - 1;
    if (idx < 0) idx = 0;
    if (idx > last) idx = last;
    return int'(idx);
  endfunction

  function automatic void taps_of(int oi, output int t [4], output int n);
    longint pos, fl;
    pos = longint'(oi) * longint'(cur_step);
    fl  = pos >>> 16;
    n = 0;
    case (cur_mode)
      MODE_NEAREST: begin
        t[0] = clamp_tap((pos + 32768) >>> 16);
        n = 1;
      end
      MODE_BILINEAR: begin
        t[0] = clamp_tap(fl);
        t[1] = clamp_tap(fl + 1);
        n = 2;
      end
      default: begin
        for (int k = 0; k < 4; k++) t[k] = clamp_tap(fl - 1 + k);
        n = 4;
      end
    endcase
  endfunction

  function automatic longint kernel_w(longint d);
    longint d2, d3, a;
    d2 = (d * d) >>> 16;
    d3 = (d2 * d) >>> 16;
    a  = cur_alpha;
    if (cur_mode == MODE_CUBIC) begin
      if (d <= 65536) return (a + 32768) * d3 - (a + 49152) * d2 + (longint'(1) << 30);
      return a * d3 - 5 * a * d2 + 8 * a * d - 4 * a * 65536;
    end
    if (d <= 65536) return 3 * d3 - 6 * d2 + 4 * 65536;
    return -d3 + 6 * d2 - 12 * d + 8 * 65536;
  endfunction

  function automatic logic [7:0] predict_pixel(int oi);
    longint pos, fl, f, sum, half, den, v;
    longint tap_dist [4];
    pos = longint'(oi) * longint'(cur_step);
    fl  = pos >>> 16;
    f   = pos & 64'hFFFF;
    if (cur_mode == MODE_NEAREST) return line_px[clamp_tap((pos + 32768) >>> 16)];
    if (cur_mode == MODE_BILINEAR) begin
      v = ((65536 - f) * line_px[clamp_tap(fl)] + f * line_px[clamp_tap(fl + 1)]
           + 32768) >>> 16;
      return (v > 255) ? 8'd255 : v[7:0];
    end
    tap_dist = '{65536 + f, f, 65536 - f, 131072 - f};
    sum = 0;
    for (int k = 0; k < 4; k++)
      sum += kernel_w(tap_dist[k]) * line_px[clamp_tap(fl - 1 + k)];
    half = (cur_mode == MODE_CUBIC) ? (longint'(1) << 29) : 3 * 65536;
    den  = (cur_mode == MODE_CUBIC) ? (longint'(1) << 30) : 6 * 65536;
    if (sum + half < 0) return 8'd0;
    v = (sum + half) / den;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_W-1:0];
    @(posedge clk_i);
    case (idx)
      REG_MODE:   cur_mode = mode_e'(value[1:0]);
      REG_STEP:   cur_step = value & 24'hFFFFFF;
      REG_ALPHA:  cur_alpha = int'(signed'(value[15:0]));
      default: begin
        cur_len = value & 11'h7FF;
        if (cur_len == 0) cur_len = 1;
        if (cur_len > STORE_DEPTH) cur_len = STORE_DEPTH;
      end
    endcase
  endtask

  task automatic drive_req(logic kind, int lidx, int pix, int oi, bit typed, int want);
    int gap;
    gap = (tx_idle && !burst) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    load_index_i <= lidx[LIDX_W-1:0];
    pixel_in_i   <= pix[PIX_W-1:0];
    out_index_i  <= oi[11:0];
    do @(posedge clk_i); while (in_stall_o);
    if (kind == KIND_LOAD) begin
      line_px[lidx]  = pix[7:0];
      line_set[lidx] = 1'b1;
    end else begin
      pixel_q.push_back(typed ? want[7:0] : predict_pixel(oi));
    end
  endtask

  // loads any tap still unwritten before the compute request
  task automatic compute_req(int oi, bit typed, int want);
    int t [4];
    int n;
    taps_of(oi, t, n);
    for (int k = 0; k < n; k++)
      if (!line_set[t[k]])
        drive_req(KIND_LOAD, t[k], $urandom_range(0, 255), $urandom_range(0, 4095), 0, 0);
    drive_req(KIND_COMPUTE, $urandom_range(0, 1023), $urandom_range(0, 255), oi, typed, want);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 6))
      0: return 1;
      1: return 65536;
      2: return 24'hFFFFFF;
      3: return 0;
      4: return $urandom_range(0, 24'hFFFFFF);
      default: return $urandom_range(2048, 160000);
    endcase
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 1024;
      3: return 2047;
      4: return $urandom_range(1, 2047);
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic int unsigned pick_alpha();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hE000;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // result side: checks and stalls
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) report("unexpected pixel_out", pixel_out_o, -1);
      else begin
        logic [7:0] want;
        want = pixel_q.pop_front();
        if (pixel_out_o !== want) report("pixel_out", pixel_out_o, want);
      end
    end
    if (hold_req) begin
      hold = LONG_HOLD;
      hold_req = 1'b0;
    end else if (out_valid_o && !out_stall_i) hold = rx_idle ? $urandom_range(0, 19) : 0;
    else if (hold > 0) hold--;
    out_stall_i <= (hold > 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("line_resampler_interp: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned st, ln, al;
    errors = 0;
    hold = 0;
    quiet = 0;
    hold_req = 1'b0;
    burst = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    cur_mode = MODE_BILINEAR;
    cur_step = 65536;
    cur_alpha = -8192;
    cur_len = 1024;
    foreach (line_set[i]) line_set[i] = 1'b0;
    foreach (line_px[i]) line_px[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == KIND_LOAD)
        drive_req(KIND_LOAD, directed[i].lidx, directed[i].pix, directed[i].oi, 0, 0);
      else compute_req(directed[i].oi, directed[i].typed, directed[i].want);
    end

    for (int p = 0; p < 14; p++) begin
      drain();
      st = (p < 4) ? ((p == 0) ? 16'h8000 : (p == 1) ? 24'hFFFFFF : (p == 2) ? 1 : 0)
                   : pick_step();
      ln = (p < 4) ? ((p == 1) ? 1024 : (p == 3) ? 2047 : 1 + p) : pick_len();
      al = (p == 2) ? 16'h8000 : (p == 6) ? 16'h7FFF : pick_alpha();
      write_reg(REG_MODE, p % 4);
      write_reg(REG_STEP, st);
      write_reg(REG_ALPHA, al);
      write_reg(REG_LENGTH, ln);
      cfg_we_i <= 1'b0;
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      burst = (p == 5);
      if (burst) hold_req = 1'b1;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 9) < 3)
          drive_req(KIND_LOAD,
                    $urandom_range(0, 1) ? $urandom_range(0, cur_len - 1)
                                         : $urandom_range(0, 1023),
                    $urandom_range(0, 255), $urandom_range(0, 4095), 0, 0);
        else compute_req($urandom_range(0, 1) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 40), 0, 0);
      end
      burst = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("line_resampler_interp: match");
    else $display("line_resampler_interp: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lri_pkg.sv
design/lri_front.sv
design/lri_queue.sv
design/lri_back.sv
design/line_resampler_interp.sv
design/lri_checker.sv
tb/sv/testbench.sv
